// ===== src/kmc_pkg.sv =====
// kmc_pkg: shared types, constants and command codes for the k-means block
// no dependencies; imported by every module of the block
`default_nettype none

package kmc_pkg;

  localparam int COORD_WIDTH    = 16;
  localparam int DIM            = 4;
  localparam int MAX_CLUSTERS   = 8;
  localparam int MAX_POINTS_DEF = 256;

  localparam int LBL_W      = $clog2(MAX_CLUSTERS);
  localparam int KW         = 4;
  localparam int ITER_W     = 10;
  localparam int STAT_W     = 2;
  localparam int PT_W       = DIM * COORD_WIDTH;
  localparam int DIST_W     = 2 * COORD_WIDTH + 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [2:0] CMD_LOAD       = 3'd0;
  localparam logic [2:0] CMD_SEED       = 3'd1;
  localparam logic [2:0] CMD_RUN        = 3'd2;
  localparam logic [2:0] CMD_READ_LABEL = 3'd3;
  localparam logic [2:0] CMD_READ_CENT  = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_CLUSTERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER     = 2'd1;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [15:0] coord_a;
    logic signed [15:0] coord_b;
    logic signed [15:0] coord_c;
    logic signed [15:0] coord_d;
    logic [7:0]         point_index;
    logic [2:0]         cluster_slot;
  } kmc_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [2:0]         label;
    logic signed [15:0] cent_a;
    logic signed [15:0] cent_b;
    logic signed [15:0] cent_c;
    logic signed [15:0] cent_d;
    logic               converged;
    logic [9:0]         iterations_done;
    logic               empty_cluster;
  } kmc_out_t;

  typedef struct packed {
    logic clear;
    logic div_start;
    logic seed_we;
  } kmc_ctrl_t;

  typedef struct packed {
    logic busy;
    logic empty;
  } kmc_stat_t;

endpackage

`default_nettype wire

// ===== src/kmc_cell.sv =====
// kmc_cell: one cluster cell of the distance chain, holding a centroid,
// its member sums and count, and a serial divider for the mean; uses kmc_pkg
`default_nettype none

module kmc_cell import kmc_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int IDX        = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   active,
  input  kmc_ctrl_t              ctrl,
  input  logic [PT_W-1:0]        seed_pt,
  input  logic                   src_vld,
  input  logic [PT_W-1:0]        src_pt,
  input  logic [LBL_W-1:0]       src_cur,
  input  logic [DIST_W-1:0]      src_best,
  input  logic [LBL_W-1:0]       src_lbl,
  output logic                   dst_vld,
  output logic [PT_W-1:0]        dst_pt,
  output logic [LBL_W-1:0]       dst_cur,
  output logic [DIST_W-1:0]      dst_best,
  output logic [LBL_W-1:0]       dst_lbl,
  input  logic                   acc_vld,
  input  logic [LBL_W-1:0]       acc_lbl,
  input  logic [PT_W-1:0]        acc_pt,
  output kmc_stat_t              stat,
  output logic [PT_W-1:0]        cent
);

  localparam int CW    = COORD_WIDTH;
  localparam int SQ_W  = 2 * CW;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SUM_W = CW + $clog2(MAX_POINTS);
  localparam int DIM_W = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int BIT_W = $clog2(SUM_W + 1);

  logic [CW-1:0]     cent_r [DIM];
  logic [SUM_W-1:0]  sum_r  [DIM];
  logic [CNT_W-1:0]  cnt_r;

  logic [CW:0]       diff   [DIM];
  logic [CW-1:0]     mag    [DIM];
  logic [SQ_W-1:0]   sq_nxt [DIM];
  logic [SQ_W-1:0]   sq_r   [DIM];
  logic              s1_vld_r;
  logic [PT_W-1:0]   s1_pt_r;
  logic [LBL_W-1:0]  s1_cur_r;
  logic [DIST_W-1:0] s1_best_r;
  logic [LBL_W-1:0]  s1_lbl_r;
  logic [DIST_W-1:0] dsum;
  logic              take;

  logic              div_busy_r;
  logic [DIM_W-1:0]  dim_r;
  logic [BIT_W-1:0]  bit_r;
  logic [SUM_W-1:0]  dvd_r;
  logic [CNT_W-1:0]  rem_r;
  logic              neg_r;
  logic [DIM_W-1:0]  ld_sel;
  logic [SUM_W-1:0]  ld_sum;
  logic [SUM_W-1:0]  ld_mag;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_sub;
  logic              ge;
  logic [CNT_W-1:0]  rem_nxt;
  logic [SUM_W-1:0]  dvd_nxt;
  logic [SUM_W-1:0]  quo;

  // squared differences per coordinate
  always_comb begin
    for (int d = 0; d < DIM; d++) begin
      diff[d] = {src_pt[d*CW + CW - 1], src_pt[d*CW +: CW]} - {cent_r[d][CW-1], cent_r[d]};
      mag[d] = diff[d][CW] ? CW'(-diff[d]) : diff[d][CW-1:0];
      sq_nxt[d] = SQ_W'(mag[d]) * SQ_W'(mag[d]);
    end
  end

  // distance and nearest-centroid choice, current label wins ties
  always_comb begin
    dsum = '0;
    for (int d = 0; d < DIM; d++) begin
      dsum = dsum + DIST_W'(sq_r[d]);
    end
    if (s1_cur_r == LBL_W'(IDX)) begin
      take = active && (dsum <= s1_best_r);
    end else begin
      take = active && (dsum < s1_best_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      dst_vld  <= 1'b0;
    end else begin
      s1_vld_r <= src_vld;
      dst_vld  <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < DIM; d++) begin
      sq_r[d] <= sq_nxt[d];
    end
    s1_pt_r   <= src_pt;
    s1_cur_r  <= src_cur;
    s1_best_r <= src_best;
    s1_lbl_r  <= src_lbl;
    dst_pt    <= s1_pt_r;
    dst_cur   <= s1_cur_r;
    dst_best  <= take ? dsum : s1_best_r;
    dst_lbl   <= take ? LBL_W'(IDX) : s1_lbl_r;
  end

  // member sums and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctrl.clear) begin
      cnt_r <= '0;
    end else if (acc_vld && acc_lbl == LBL_W'(IDX)) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      for (int d = 0; d < DIM; d++) begin
        sum_r[d] <= '0;
      end
    end else if (acc_vld && acc_lbl == LBL_W'(IDX)) begin
      for (int d = 0; d < DIM; d++) begin
        sum_r[d] <= sum_r[d] + SUM_W'($signed(acc_pt[d*CW +: CW]));
      end
    end
  end

  // restoring divider, one quotient bit per cycle, one coordinate at a time
  always_comb begin
    ld_sel  = div_busy_r ? DIM_W'(dim_r + 1'b1) : '0;
    ld_sum  = sum_r[ld_sel];
    ld_mag  = ld_sum[SUM_W-1] ? -ld_sum : ld_sum;
    rem_sh  = {rem_r, dvd_r[SUM_W-1]};
    rem_sub = rem_sh - {1'b0, cnt_r};
    ge      = rem_sh >= {1'b0, cnt_r};
    rem_nxt = ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    dvd_nxt = {dvd_r[SUM_W-2:0], ge};
    quo     = neg_r ? -dvd_nxt : dvd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      dim_r      <= '0;
      bit_r      <= '0;
    end else if (ctrl.div_start && active && cnt_r != '0) begin
      div_busy_r <= 1'b1;
      dim_r      <= '0;
      bit_r      <= '0;
    end else if (div_busy_r) begin
      if (bit_r == BIT_W'(SUM_W - 1)) begin
        bit_r <= '0;
        if (dim_r == DIM_W'(DIM - 1)) begin
          div_busy_r <= 1'b0;
        end else begin
          dim_r <= dim_r + 1'b1;
        end
      end else begin
        bit_r <= bit_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.seed_we) begin
      for (int d = 0; d < DIM; d++) begin
        cent_r[d] <= seed_pt[d*CW +: CW];
      end
    end
    if (ctrl.div_start && active && cnt_r != '0) begin
      dvd_r <= ld_mag;
      rem_r <= '0;
      neg_r <= ld_sum[SUM_W-1];
    end else if (div_busy_r) begin
      if (bit_r == BIT_W'(SUM_W - 1)) begin
        cent_r[dim_r] <= quo[CW-1:0];
        dvd_r <= ld_mag;
        rem_r <= '0;
        neg_r <= ld_sum[SUM_W-1];
      end else begin
        dvd_r <= dvd_nxt;
        rem_r <= rem_nxt;
      end
    end
  end

  always_comb begin
    for (int d = 0; d < DIM; d++) begin
      cent[d*CW +: CW] = cent_r[d];
    end
    stat.busy  = div_busy_r;
    stat.empty = (cnt_r == '0);
  end

endmodule

`default_nettype wire

// ===== src/kmeans_lloyd_clustering.sv =====
// kmeans_lloyd_clustering: top level, point and label memories, command
// decode, run sequencer and the chain of kmc_cell; uses kmc_pkg
//
// channel   ports                                   transfer
// input     start, busy, in_item                    start & !busy
// result    out_strobe, out_item                    one cycle, no stall
// config    cfg_valid, cfg_ready, cfg_index, cfg_wdata   cfg_valid & cfg_ready
//
// load, seed, read label and read centroid do not raise busy; each of their
// results passes the p1 register and then the result register.
// run holds busy for up to max_iter iterations, each of them set by streaming
// N points through the cell chain and by the serial mean dividers.
// reset is synchronous; no memory clearing pass is needed.
`default_nettype none

module kmeans_lloyd_clustering import kmc_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  kmc_in_t               in_item,
  output logic                  out_strobe,
  output kmc_out_t              out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW     = COORD_WIDTH;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int PTR_W  = $clog2(MAX_POINTS);
  localparam int IDXC_W = (CNT_W > 8) ? CNT_W : 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS,
    ST_DRAIN,
    ST_DIV,
    ST_DIVW
  } state_t;

  state_t            state_r;
  logic [KW-1:0]     nclu_r;
  logic [ITER_W-1:0] maxit_r;
  logic [CNT_W-1:0]  count_r;
  logic [KW-1:0]     k_eff;

  logic [PT_W-1:0]   pt_mem  [MAX_POINTS];
  logic [LBL_W-1:0]  lbl_mem [MAX_POINTS];
  logic [PT_W-1:0]   pt_rd_r;
  logic [LBL_W-1:0]  lbl_rd_r;
  logic [PTR_W-1:0]  rd_addr;
  logic [PT_W-1:0]   pt_in;

  logic              accept;
  logic              idx_ok;
  logic              slot_ok;
  logic [STAT_W-1:0] status;
  logic              run_go;
  logic              pt_we;

  logic              p1_vld_r;
  logic [2:0]        p1_cmd_r;
  logic [STAT_W-1:0] p1_status_r;
  logic [LBL_W-1:0]  p1_slot_r;
  logic              zl_r;
  kmc_out_t          p1_out;
  kmc_out_t          run_out;
  logic              seed_we;

  logic [CNT_W-1:0]  rd_idx_r;
  logic [CNT_W-1:0]  wr_idx_r;
  logic [ITER_W-1:0] iter_r;
  logic              first_r;
  logic              changed_r;
  logic              clr_r;
  logic              feed_vld_r;
  logic              out_valid_r;
  kmc_out_t          out_r;

  logic              ch_vld  [MAX_CLUSTERS+1];
  logic [PT_W-1:0]   ch_pt   [MAX_CLUSTERS+1];
  logic [LBL_W-1:0]  ch_cur  [MAX_CLUSTERS+1];
  logic [DIST_W-1:0] ch_best [MAX_CLUSTERS+1];
  logic [LBL_W-1:0]  ch_lbl  [MAX_CLUSTERS+1];
  kmc_ctrl_t         ctrl    [MAX_CLUSTERS];
  kmc_stat_t         cstat   [MAX_CLUSTERS];
  logic [PT_W-1:0]   cent_all[MAX_CLUSTERS];
  logic [MAX_CLUSTERS-1:0] active;
  logic              all_idle;
  logic              empty_any;
  logic              end_vld;
  logic [LBL_W-1:0]  end_lbl;
  logic [LBL_W-1:0]  end_cur;
  logic [PT_W-1:0]   sel_cent;

  assign cfg_ready  = 1'b1;
  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_valid_r;
  assign out_item   = out_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nclu_r  <= KW'(2);
      maxit_r <= ITER_W'(100);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NUM_CLUSTERS: nclu_r  <= cfg_wdata[KW-1:0];
        REG_MAX_ITER:     maxit_r <= cfg_wdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (nclu_r == '0) begin
      k_eff = KW'(1);
    end else if (nclu_r > KW'(MAX_CLUSTERS)) begin
      k_eff = KW'(MAX_CLUSTERS);
    end else begin
      k_eff = nclu_r;
    end
    for (int c = 0; c < MAX_CLUSTERS; c++) begin
      active[c] = KW'(c) < k_eff;
    end
  end

  // command decode
  assign accept  = start && !busy;
  assign idx_ok  = IDXC_W'(in_item.point_index) < IDXC_W'(count_r);
  assign slot_ok = {1'b0, in_item.cluster_slot} < k_eff;
  assign pt_in   = {in_item.coord_d, in_item.coord_c, in_item.coord_b, in_item.coord_a};

  always_comb begin
    unique case (in_item.cmd)
      CMD_LOAD:       status = (count_r == CNT_W'(MAX_POINTS)) ? STAT_FULL : STAT_OK;
      CMD_SEED:       status = (idx_ok && slot_ok) ? STAT_OK : STAT_BAD;
      CMD_RUN:        status = (count_r != '0) ? STAT_OK : STAT_BAD;
      CMD_READ_LABEL: status = idx_ok ? STAT_OK : STAT_BAD;
      CMD_READ_CENT:  status = slot_ok ? STAT_OK : STAT_BAD;
      default:        status = STAT_BAD;
    endcase
  end

  assign run_go = accept && in_item.cmd == CMD_RUN && count_r != '0 && maxit_r != '0;
  assign pt_we  = accept && in_item.cmd == CMD_LOAD && status == STAT_OK;

  // point and label memories
  assign rd_addr = (state_r == ST_PASS) ? rd_idx_r[PTR_W-1:0] : PTR_W'(in_item.point_index);

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[count_r[PTR_W-1:0]] <= pt_in;
    end
    pt_rd_r <= pt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (end_vld) begin
      lbl_mem[wr_idx_r[PTR_W-1:0]] <= end_lbl;
    end
    lbl_rd_r <= lbl_mem[rd_addr];
  end

  // cell chain
  assign ch_vld[0]  = feed_vld_r;
  assign ch_pt[0]   = pt_rd_r;
  assign ch_cur[0]  = first_r ? '0 : lbl_rd_r;
  assign ch_best[0] = '1;
  assign ch_lbl[0]  = '0;

  assign end_vld = ch_vld[MAX_CLUSTERS];
  assign end_lbl = ch_lbl[MAX_CLUSTERS];
  assign end_cur = ch_cur[MAX_CLUSTERS];
  assign seed_we = p1_vld_r && p1_cmd_r == CMD_SEED && p1_status_r == STAT_OK;

  for (genvar c = 0; c < MAX_CLUSTERS; c++) begin : g_cell
    assign ctrl[c].clear     = clr_r;
    assign ctrl[c].div_start = (state_r == ST_DIV);
    assign ctrl[c].seed_we   = seed_we && p1_slot_r == LBL_W'(c);

    kmc_cell #(
      .MAX_POINTS (MAX_POINTS),
      .IDX        (c)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .active   (active[c]),
      .ctrl     (ctrl[c]),
      .seed_pt  (pt_rd_r),
      .src_vld  (ch_vld[c]),
      .src_pt   (ch_pt[c]),
      .src_cur  (ch_cur[c]),
      .src_best (ch_best[c]),
      .src_lbl  (ch_lbl[c]),
      .dst_vld  (ch_vld[c+1]),
      .dst_pt   (ch_pt[c+1]),
      .dst_cur  (ch_cur[c+1]),
      .dst_best (ch_best[c+1]),
      .dst_lbl  (ch_lbl[c+1]),
      .acc_vld  (end_vld),
      .acc_lbl  (end_lbl),
      .acc_pt   (ch_pt[MAX_CLUSTERS]),
      .stat     (cstat[c]),
      .cent     (cent_all[c])
    );
  end

  always_comb begin
    all_idle  = 1'b1;
    empty_any = 1'b0;
    for (int c = 0; c < MAX_CLUSTERS; c++) begin
      if (cstat[c].busy) begin
        all_idle = 1'b0;
      end
      if (active[c] && cstat[c].empty) begin
        empty_any = 1'b1;
      end
    end
  end

  // result of a short command
  assign sel_cent = cent_all[p1_slot_r];

  always_comb begin
    p1_out        = '0;
    p1_out.status = p1_status_r;
    if (p1_status_r == STAT_OK) begin
      unique case (p1_cmd_r)
        CMD_READ_LABEL: p1_out.label = zl_r ? '0 : lbl_rd_r;
        CMD_READ_CENT: begin
          p1_out.cent_a = sel_cent[0*CW +: CW];
          p1_out.cent_b = sel_cent[1*CW +: CW];
          p1_out.cent_c = sel_cent[2*CW +: CW];
          p1_out.cent_d = sel_cent[3*CW +: CW];
        end
        default: ;
      endcase
    end
  end

  // result of a run
  always_comb begin
    run_out                 = '0;
    run_out.status          = STAT_OK;
    run_out.converged       = !changed_r;
    run_out.iterations_done = iter_r;
    run_out.empty_cluster   = empty_any;
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      p1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      clr_r       <= 1'b0;
      feed_vld_r  <= 1'b0;
      zl_r        <= 1'b0;
      first_r     <= 1'b0;
      changed_r   <= 1'b0;
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      iter_r      <= '0;
    end else begin
      clr_r       <= 1'b0;
      out_valid_r <= 1'b0;
      feed_vld_r  <= (state_r == ST_PASS);
      p1_vld_r    <= accept && !run_go;
      p1_cmd_r    <= in_item.cmd;
      p1_status_r <= status;
      p1_slot_r   <= in_item.cluster_slot;

      if (p1_vld_r) begin
        out_valid_r <= 1'b1;
        out_r       <= p1_out;
      end
      if (pt_we) begin
        count_r <= count_r + 1'b1;
      end
      if (accept && in_item.cmd == CMD_RUN && count_r != '0) begin
        zl_r <= (maxit_r == '0);
      end
      if (end_vld) begin
        wr_idx_r <= wr_idx_r + 1'b1;
        if (end_lbl != end_cur) begin
          changed_r <= 1'b1;
        end
      end

      unique case (state_r)
        ST_IDLE: begin
          if (run_go) begin
            state_r   <= ST_PASS;
            iter_r    <= '0;
            first_r   <= 1'b1;
            changed_r <= 1'b0;
            rd_idx_r  <= '0;
            wr_idx_r  <= '0;
            clr_r     <= 1'b1;
          end
        end
        ST_PASS: begin
          rd_idx_r <= rd_idx_r + 1'b1;
          if (rd_idx_r == count_r - 1'b1) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (wr_idx_r == count_r) begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          state_r <= ST_DIVW;
        end
        ST_DIVW: begin
          if (all_idle) begin
            if (!changed_r || iter_r == maxit_r - 1'b1) begin
              state_r     <= ST_IDLE;
              out_valid_r <= 1'b1;
              out_r       <= run_out;
            end else begin
              state_r   <= ST_PASS;
              iter_r    <= iter_r + 1'b1;
              first_r   <= 1'b0;
              changed_r <= 1'b0;
              rd_idx_r  <= '0;
              wr_idx_r  <= '0;
              clr_r     <= 1'b1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/kmc_checker.sv =====
// kmc_checker: port-level assertions for kmeans_lloyd_clustering
// bound to the top level below; uses kmc_pkg
`default_nettype none

module kmc_checker import kmc_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input kmc_in_t               in_item,
  input logic                  out_strobe,
  input kmc_out_t              out_item,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_wdata
);

  // a short command that is taken is answered with an item
  a_short_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.cmd != CMD_RUN) |-> ##2 out_strobe)
    else $error("short command gave no item");

  // a finishing run always delivers its item
  a_run_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("run ended without item");

  a_conv_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.converged) |->
      (out_item.status == STAT_OK && out_item.label == '0))
    else $error("converged flag on wrong item");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status != STAT_OK) |->
      (out_item.label == '0 && out_item.cent_a == '0 && !out_item.converged &&
       out_item.iterations_done == '0 && !out_item.empty_cluster))
    else $error("error item carries data");

endmodule

bind kmeans_lloyd_clustering kmc_checker u_kmc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_item    (in_item),
  .out_strobe (out_strobe),
  .out_item   (out_item),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .cfg_index  (cfg_index),
  .cfg_wdata  (cfg_wdata)
);

`default_nettype wire
